// ----- hdl/clge_pkg.sv -----
// Shared types and constants for the cursor list group extract block.
// Used by the channel interfaces, the front decoder, the command queue and the engine.
package clge_pkg;

  localparam int OP_W          = 2;
  localparam int LIST_ID_W     = 2;
  localparam int GROUP_W       = 8;
  localparam int PAYLOAD_W     = 32;
  localparam int STATUS_W      = 2;
  localparam int NODE_IDX_W    = 5;
  localparam int MOVED_W       = 6;

  localparam int DEF_NODE_COUNT = 32;
  localparam int DEF_LIST_COUNT = 4;
  localparam int CMDQ_DEPTH     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_HEAP_FULL = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    E_INIT,
    E_IDLE,
    E_INS_WR,
    E_EXT_WALK,
    E_RD_WALK,
    E_EMIT
  } eng_state_t;

  // Classified command, list numbers already wrapped into range
  typedef struct packed {
    op_t                  op;
    logic [LIST_ID_W-1:0] src;
    logic [LIST_ID_W-1:0] dst;
    logic [GROUP_W-1:0]   group;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic [NODE_IDX_W-1:0] node_index;
    logic [GROUP_W-1:0]    entry_group;
    logic [PAYLOAD_W-1:0]  entry_payload;
    logic [MOVED_W-1:0]    moved_count;
    logic                  last;
  } res_t;

endpackage

// ----- hdl/clge_chan_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
// Depends on clge_pkg for field widths.
interface clge_in_if import clge_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [LIST_ID_W-1:0] list_id;
  logic [LIST_ID_W-1:0] dest_list;
  logic [GROUP_W-1:0]   group;
  logic [PAYLOAD_W-1:0] payload;

  modport source(output valid, op, list_id, dest_list, group, payload, input ready);
  modport sink(input valid, op, list_id, dest_list, group, payload, output ready);
endinterface

interface clge_out_if import clge_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [NODE_IDX_W-1:0] node_index;
  logic [GROUP_W-1:0]    entry_group;
  logic [PAYLOAD_W-1:0]  entry_payload;
  logic [MOVED_W-1:0]    moved_count;
  logic                  last;

  modport source(output valid, status, node_index, entry_group, entry_payload, moved_count,
                 last, input ready);
  modport sink(input valid, status, node_index, entry_group, entry_payload, moved_count,
               last, output ready);
endinterface

// ----- hdl/cursor_list_group_extract.sv -----
// Node table shared by LIST_COUNT singly linked lists plus a free list. After reset the
// block runs a clearing pass over every node that chains the free list; no input
// transfer is taken until it ends. Insert writes the free head node in E_INS_WR and
// returns its result from E_EMIT. Extract and read walk a list node by node: the node table
// has one read port, so a walk advances one node per cycle, and a read walk also holds
// while its result register is stalled. A two-entry command queue lets new items be
// taken while a walk is still running.
module cursor_list_group_extract import clge_pkg::*; #(
  parameter int NODE_COUNT = DEF_NODE_COUNT,
  parameter int LIST_COUNT = DEF_LIST_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  clge_in_if.sink    in_chan,
  clge_out_if.source out_chan
);

  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_pop_data;
  logic init_done;

  clge_front #(
    .LIST_COUNT(LIST_COUNT)
  ) u_front (
    .in_chan   (in_chan),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  clge_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  clge_engine #(
    .NODE_COUNT(NODE_COUNT),
    .LIST_COUNT(LIST_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_chan  (out_chan)
  );

endmodule

// ----- hdl/clge_front.sv -----
// Front end: accepts input transfers, wraps list numbers and drops unused op codes.
// Depends on clge_pkg and clge_in_if; feeds the command queue.
module clge_front import clge_pkg::*; #(
  parameter int LIST_COUNT = DEF_LIST_COUNT
) (
  clge_in_if.sink     in_chan,
  input  logic        init_done,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  function automatic logic [LIST_ID_W-1:0] wrap_list(input logic [LIST_ID_W-1:0] v);
    logic [LIST_ID_W-1:0] r;
    r = v;
    if (r >= LIST_COUNT) r = r - LIST_ID_W'(LIST_COUNT);
    if (r >= LIST_COUNT) r = r - LIST_ID_W'(LIST_COUNT);
    return r;
  endfunction

  logic known_op;

  always_comb begin
    unique case (in_chan.op)
      OP_INSERT, OP_EXTRACT, OP_READ: known_op = 1'b1;
      default:                        known_op = 1'b0;
    endcase
  end

  assign in_chan.ready = init_done && !q_full;
  assign q_push        = in_chan.valid && in_chan.ready && known_op;

  always_comb begin
    q_data.op      = op_t'(in_chan.op);
    q_data.src     = wrap_list(in_chan.list_id);
    q_data.dst     = wrap_list(in_chan.dest_list);
    q_data.group   = in_chan.group;
    q_data.payload = in_chan.payload;
  end

endmodule

// ----- hdl/clge_cmdq.sv -----
// Small command FIFO between the front end and the list engine.
// Depends on clge_pkg for cmd_t and the queue depth.
module clge_cmdq import clge_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_data
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(CMDQ_DEPTH - 1);

  cmd_t          slot_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(CMDQ_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(CMDQ_DEPTH)) || pop)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command queue underflow");

endmodule

// ----- hdl/clge_engine.sv -----
// List engine: node table memories, free list, list heads and the walk sequencer.
// Depends on clge_pkg and clge_out_if; takes commands from the command queue.
module clge_engine import clge_pkg::*; #(
  parameter int NODE_COUNT = DEF_NODE_COUNT,
  parameter int LIST_COUNT = DEF_LIST_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        init_done,
  clge_out_if.source  out_chan
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int NW = $clog2(NODE_COUNT + 1);
  localparam int LW = $clog2(LIST_COUNT);
  localparam logic [NW-1:0] NULL_NODE = NW'(NODE_COUNT);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NODE_COUNT - 1);

  // Node table
  logic [NW-1:0]        next_mem [NODE_COUNT];
  logic [GROUP_W-1:0]   grp_mem  [NODE_COUNT];
  logic [PAYLOAD_W-1:0] pay_mem  [NODE_COUNT];

  logic [NW-1:0]        rd_next_r;
  logic [GROUP_W-1:0]   rd_grp_r;
  logic [PAYLOAD_W-1:0] rd_pay_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          we_next;
  logic [IW-1:0] wa_next;
  logic [NW-1:0] wd_next;
  logic          we_data;

  eng_state_t    state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] prev_r, prev_nxt;
  logic [NW-1:0] pend_r, pend_nxt;
  logic          dirty_r, dirty_nxt;
  logic [NW-1:0] steps_r, steps_nxt;
  logic [NW-1:0] moved_r, moved_nxt;
  logic [NW-1:0] free_r, free_nxt;
  logic [NW-1:0] heads_r [LIST_COUNT];
  logic [NW-1:0] heads_nxt [LIST_COUNT];
  logic [IW-1:0] init_idx_r, init_idx_nxt;
  res_t          res_r, res_nxt;
  res_t          out_res_r, out_res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [LW-1:0] src_idx, dst_idx, q_src_idx;
  logic [NW-1:0] q_head;
  logic [NW-1:0] step_cnt;
  logic          at_end;
  logic          out_free;
  logic          match;

  assign src_idx   = LW'(cmd_r.src);
  assign dst_idx   = LW'(cmd_r.dst);
  assign q_src_idx = LW'(q_data.src);
  assign q_head    = heads_r[q_src_idx];
  assign step_cnt  = steps_r + NW'(1);
  assign at_end    = (rd_next_r == NULL_NODE) || (step_cnt == NULL_NODE);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign match     = (rd_grp_r == cmd_r.group);
  assign init_done = (state_r != E_INIT);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    dirty_nxt     = dirty_r;
    steps_nxt     = steps_r;
    moved_nxt     = moved_r;
    free_nxt      = free_r;
    heads_nxt     = heads_r;
    init_idx_nxt  = init_idx_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = cur_r[IW-1:0];
    we_next       = 1'b0;
    wa_next       = '0;
    wd_next       = '0;
    we_data       = 1'b0;
    q_pop         = 1'b0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      E_INIT: begin
        // chain every node into the free list in index order
        we_next = 1'b1;
        wa_next = init_idx_r;
        wd_next = NW'(init_idx_r) + NW'(1);
        if (init_idx_r == LAST_IDX) begin
          state_nxt = E_IDLE;
        end else begin
          init_idx_nxt = init_idx_r + IW'(1);
        end
      end

      E_IDLE: begin
        if (q_valid) begin
          q_pop                 = 1'b1;
          cmd_nxt               = q_data;
          res_nxt.status        = ST_OK;
          res_nxt.node_index    = '0;
          res_nxt.entry_group   = '0;
          res_nxt.entry_payload = '0;
          res_nxt.moved_count   = '0;
          res_nxt.last          = 1'b1;
          unique case (q_data.op)
            OP_INSERT: begin
              if (free_r == NULL_NODE) begin
                res_nxt.status = ST_HEAP_FULL;
                state_nxt      = E_EMIT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = free_r[IW-1:0];
                state_nxt = E_INS_WR;
              end
            end
            OP_EXTRACT: begin
              if (q_data.src == q_data.dst || q_head == NULL_NODE) begin
                state_nxt = E_EMIT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = q_head[IW-1:0];
                cur_nxt   = q_head;
                prev_nxt  = NULL_NODE;
                dirty_nxt = 1'b0;
                steps_nxt = '0;
                moved_nxt = '0;
                state_nxt = E_EXT_WALK;
              end
            end
            OP_READ: begin
              if (q_head == NULL_NODE) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = E_EMIT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = q_head[IW-1:0];
                cur_nxt   = q_head;
                steps_nxt = '0;
                state_nxt = E_RD_WALK;
              end
            end
            default: state_nxt = E_IDLE;
          endcase
        end
      end

      E_INS_WR: begin
        free_nxt           = rd_next_r;
        we_next            = 1'b1;
        wa_next            = free_r[IW-1:0];
        wd_next            = heads_r[src_idx];
        we_data            = 1'b1;
        heads_nxt[src_idx] = free_r;
        res_nxt.node_index = NODE_IDX_W'(free_r);
        state_nxt          = E_EMIT;
      end

      E_EXT_WALK: begin
        if (match) begin
          // unlink cur; the link of prev is held and written when prev changes
          if (prev_r == NULL_NODE) begin
            heads_nxt[src_idx] = rd_next_r;
          end else begin
            pend_nxt  = rd_next_r;
            dirty_nxt = 1'b1;
          end
          we_next            = 1'b1;
          wa_next            = cur_r[IW-1:0];
          wd_next            = heads_r[dst_idx];
          heads_nxt[dst_idx] = cur_r;
          moved_nxt          = moved_r + NW'(1);
        end else begin
          if (dirty_r) begin
            we_next = 1'b1;
            wa_next = prev_r[IW-1:0];
            wd_next = pend_r;
          end
          dirty_nxt = 1'b0;
          prev_nxt  = cur_r;
        end
        steps_nxt = step_cnt;
        cur_nxt   = rd_next_r;
        if (at_end) begin
          res_nxt.moved_count = MOVED_W'(moved_nxt);
          state_nxt           = E_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_next_r[IW-1:0];
        end
      end

      E_RD_WALK: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.status        = ST_OK;
          out_res_nxt.node_index    = NODE_IDX_W'(cur_r);
          out_res_nxt.entry_group   = rd_grp_r;
          out_res_nxt.entry_payload = rd_pay_r;
          out_res_nxt.moved_count   = '0;
          out_res_nxt.last          = at_end;
          if (at_end) begin
            state_nxt = E_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = rd_next_r[IW-1:0];
            cur_nxt   = rd_next_r;
            steps_nxt = step_cnt;
          end
        end
      end

      E_EMIT: begin
        // flush a held link left over from extract
        if (dirty_r) begin
          we_next   = 1'b1;
          wa_next   = prev_r[IW-1:0];
          wd_next   = pend_r;
          dirty_nxt = 1'b0;
        end
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = E_IDLE;
        end
      end

      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_idx_r  <= '0;
      free_r      <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        heads_r[i] <= NULL_NODE;
      end
    end else begin
      init_idx_r  <= init_idx_nxt;
      free_r      <= free_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      heads_r     <= heads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    pend_r    <= pend_nxt;
    steps_r   <= steps_nxt;
    moved_r   <= moved_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_next) next_mem[wa_next] <= wd_next;
    if (we_data) begin
      grp_mem[free_r[IW-1:0]] <= cmd_r.group;
      pay_mem[free_r[IW-1:0]] <= cmd_r.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr];
      rd_grp_r  <= grp_mem[rd_addr];
      rd_pay_r  <= pay_mem[rd_addr];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.node_index    = out_res_r.node_index;
  assign out_chan.entry_group   = out_res_r.entry_group;
  assign out_chan.entry_payload = out_res_r.entry_payload;
  assign out_chan.moved_count   = out_res_r.moved_count;
  assign out_chan.last          = out_res_r.last;

  a_ext_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_EXT_WALK |-> (cur_r != NULL_NODE) && (steps_r < NULL_NODE))
    else $error("extract walk on a null node or past the step limit");

  a_ins_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_INS_WR |-> free_r != NULL_NODE)
    else $error("insert writing with an empty free list");

  a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_EXT_WALK |-> moved_r <= steps_r)
    else $error("extract moved more nodes than it visited");

endmodule
